[rtl/u8dl_pkg.sv]
// Shared types and constants for the UTF-8 decoder with Latin-1 fallback.
// No dependencies.
package u8dl_pkg;

    localparam int unsigned WIN_DEPTH = 4;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned CP_W      = 21;

    localparam logic [1:0]      CONT_TAG = 2'b10;
    localparam logic [CP_W-1:0] TAB_CODE = 21'h00009;
    localparam logic [CP_W-1:0] TAB_REPL = 21'h02007;

    typedef logic [CNT_W-1:0] count_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            final_char;
    } result_t;

endpackage

[rtl/u8dl_front.sv]
// Front end: lookahead window, byte intake and one code point decode per cycle while the queue has room.
// Depends on u8dl_pkg.
module u8dl_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_text,
    output logic               push_valid,
    input  logic               push_ready,
    output u8dl_pkg::result_t  push_data
);
    import u8dl_pkg::*;

    logic [7:0] win_reg   [WIN_DEPTH];
    logic [7:0] win_next  [WIN_DEPTH];
    logic [7:0] shifted   [WIN_DEPTH];
    logic [7:0] c         [WIN_DEPTH];
    count_t     count_reg;
    count_t     count_next;
    logic       flush_reg;
    logic       flush_next;

    count_t          len;
    count_t          good;
    count_t          used;
    count_t          remain;
    count_t          base_count;
    logic [CP_W-1:0] cp;
    logic            do_dec;
    logic            dec_fire;
    logic            accept;
    logic            last_out;

    // decode from the front of the window; slots past the fill read as zero
    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            c[i] = (CNT_W'(i) < count_reg) ? win_reg[i] : 8'h00;
        end

        case (c[0]) inside
            8'b110?????: len = 3'd2;
            8'b1110????: len = 3'd3;
            8'b11110???: len = 3'd4;
            default:     len = 3'd1;
        endcase

        good = 3'd1 + {2'b00, c[1][7:6] == CONT_TAG}
                    + {2'b00, c[2][7:6] == CONT_TAG}
                    + {2'b00, c[3][7:6] == CONT_TAG};
        used = (len <= good) ? len : 3'd1;

        case (used)
            3'd2:    cp = {10'b0, c[0][4:0], c[1][5:0]};
            3'd3:    cp = {5'b0, c[0][3:0], c[1][5:0], c[2][5:0]};
            3'd4:    cp = {c[0][2:0], c[1][5:0], c[2][5:0], c[3][5:0]};
            default: cp = {13'b0, c[0]};
        endcase
        if (cp == TAB_CODE)
        begin
            cp = TAB_REPL;
        end

        remain = count_reg - used;
    end

    always_comb
    begin
        shifted = win_reg;
        case (used)
            3'd1:
            begin
                shifted[0] = win_reg[1];
                shifted[1] = win_reg[2];
                shifted[2] = win_reg[3];
            end
            3'd2:
            begin
                shifted[0] = win_reg[2];
                shifted[1] = win_reg[3];
            end
            3'd3:
            begin
                shifted[0] = win_reg[3];
            end
            default:
            begin
                shifted = win_reg;
            end
        endcase
    end

    assign do_dec   = (count_reg == CNT_W'(WIN_DEPTH)) || (flush_reg && (count_reg != '0));
    assign dec_fire = do_dec && push_ready;
    assign in_ready = !flush_reg && ((count_reg != CNT_W'(WIN_DEPTH)) || push_ready);
    assign accept   = in_valid && in_ready;
    assign last_out = flush_reg && (remain == '0);

    assign push_valid = do_dec;
    assign push_data  = {cp, last_out};

    always_comb
    begin
        win_next   = win_reg;
        base_count = count_reg;
        if (dec_fire)
        begin
            win_next   = shifted;
            base_count = remain;
        end
        count_next = base_count;
        if (accept)
        begin
            win_next[base_count[1:0]] = data_byte;
            count_next                = base_count + 3'd1;
        end

        flush_next = flush_reg;
        if (accept && end_of_text)
        begin
            flush_next = 1'b1;
        end
        else if (dec_fire && last_out)
        begin
            flush_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            flush_reg <= flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WIN_DEPTH))
        else $error("window count overflow");

    a_final_ends_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_fire && last_out) |=> (!flush_reg && (count_reg == '0)))
        else $error("final request left bytes behind");

    a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_text) |=> !in_ready)
        else $error("input taken during flush");
`endif

endmodule

[rtl/u8dl_fifo.sv]
// Short request queue between decoder front end and output stage.
// Depends on u8dl_pkg.
module u8dl_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  u8dl_pkg::result_t  push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output u8dl_pkg::result_t  pop_data
);
    import u8dl_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FIL_W = $clog2(DEPTH + 1);

    result_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FIL_W-1:0]  fill_reg;
    logic [FIL_W-1:0]  fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != FIL_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/u8dl_back.sv]
// Output stage: registered request toward the consumer.
// Depends on u8dl_pkg.
module u8dl_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  u8dl_pkg::result_t  pop_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [20:0]        code_point,
    output logic               final_char
);
    import u8dl_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    logic    load;

    assign pop_ready  = !out_valid_reg || out_ready;
    assign load       = pop_valid && pop_ready;
    assign out_valid  = out_valid_reg;
    assign code_point = out_data_reg.code_point;
    assign final_char = out_data_reg.final_char;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= pop_data;
        end
    end

endmodule

[rtl/utf8_decoder_latin1_fallback_top.sv]
// Top level of the UTF-8 decoder with Latin-1 fallback.
// Depends on u8dl_pkg, u8dl_front, u8dl_fifo, u8dl_back.
//
// channel  handshake             payload
// -------  --------------------  --------------------------------
// in       in_valid / in_ready   data_byte[7:0], end_of_text
// out      out_valid / out_ready code_point[20:0], final_char
//
// One byte per cycle in steady state while the queue has room; a full window is offered
// for decode in the cycle after it fills. After an end_of_text byte the window drains
// at one code point per cycle while the queue has room, and in_ready stays low until
// the final request is queued. A request passes front decode, queue, output register.
// rst_n clears the window fill, flush flag, queue and output valid; window bytes
// are not reset. Either side may stall; QUEUE_DEPTH requests buffer between them.
module utf8_decoder_latin1_fallback_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic        final_char
);
    import u8dl_pkg::*;

    logic    push_valid;
    logic    push_ready;
    result_t push_data;
    logic    pop_valid;
    logic    pop_ready;
    result_t pop_data;

    u8dl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    u8dl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    u8dl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .final_char (final_char)
    );

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for utf8_decoder_latin1_fallback_top: byte stream in, code points out,
// each result checked against a local window-decoding predictor. Depends on u8dl_pkg.
module tb_top;
    import u8dl_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [20:0] code_point;
    logic        final_char;

    logic        idle_en = 1'b1;
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned ready_hold = 0;

    // predictor state
    logic [7:0]  win_bytes[WIN_DEPTH];
    int unsigned win_fill = 0;
    result_t     pending_chars[$];

    utf8_decoder_latin1_fallback_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .final_char  (final_char)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    // decode one code point from the front of the window and drop its bytes
    task automatic decode_front(output logic [20:0] cp);
        logic [7:0]  c[WIN_DEPTH];
        int unsigned len;
        int unsigned good;
        int unsigned used;
        for (int i = 0; i < WIN_DEPTH; i++)
            c[i] = (i < win_fill) ? win_bytes[i] : 8'h00;
        len = 0;
        while (len < 8 && c[0][7 - len])
            len++;
        if (len == 0 || len > 4)
            len = 1;
        good = 1;
        for (int i = 1; i < WIN_DEPTH; i++)
            if (c[i][7:6] == CONT_TAG)
                good++;
        used = (len <= good) ? len : 1;
        case (used)
            2: cp = {10'b0, c[0][4:0], c[1][5:0]};
            3: cp = {5'b0, c[0][3:0], c[1][5:0], c[2][5:0]};
            4: cp = {c[0][2:0], c[1][5:0], c[2][5:0], c[3][5:0]};
            default: cp = {13'b0, c[0]};
        endcase
        if (used > win_fill)
            used = win_fill;
        for (int i = 0; i < WIN_DEPTH; i++)
            win_bytes[i] = (i + used < WIN_DEPTH) ? win_bytes[i + used] : 8'h00;
        win_fill -= used;
        if (cp == TAB_CODE)
            cp = TAB_REPL;
    endtask

    task automatic predict_code_points(input logic [7:0] b, input logic last);
        result_t     r;
        logic [20:0] cp;
        win_bytes[win_fill] = b;
        win_fill++;
        if (!last)
        begin
            if (win_fill == WIN_DEPTH)
            begin
                decode_front(cp);
                r.code_point = cp;
                r.final_char = 1'b0;
                pending_chars.insert(pending_chars.size(), r);
            end
        end
        else
        begin
            while (win_fill > 0)
            begin
                decode_front(cp);
                r.code_point = cp;
                r.final_char = (win_fill == 0);
                pending_chars.insert(pending_chars.size(), r);
            end
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_en && $urandom_range(0, 99) < 5)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_text <= last;
        do
            @(posedge clk);
        while (!in_ready);
        predict_code_points(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input byte_q_t txt);
        foreach (txt[i])
            send_byte(txt[i], i == txt.size() - 1);
    endtask

    task automatic add_byte(ref byte_q_t txt, input logic [7:0] b);
        txt.insert(txt.size(), b);
    endtask

    // mostly well-formed characters, some broken sequences and noise
    task automatic append_char(ref byte_q_t txt);
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 99);
        if (kind < 30)
            add_byte(txt, 8'($urandom_range(0, 127)));
        else if (kind < 35)
            add_byte(txt, 8'h09);
        else if (kind < 55)
        begin
            add_byte(txt, {3'b110, 5'($urandom)});
            add_byte(txt, {2'b10, 6'($urandom)});
        end
        else if (kind < 70)
        begin
            add_byte(txt, {4'b1110, 4'($urandom)});
            repeat (2) add_byte(txt, {2'b10, 6'($urandom)});
        end
        else if (kind < 80)
        begin
            add_byte(txt, {5'b11110, 3'($urandom)});
            repeat (3) add_byte(txt, {2'b10, 6'($urandom)});
        end
        else if (kind < 90)
        begin
            n = $urandom_range(2, 4);
            case (n)
                2: add_byte(txt, {3'b110, 5'($urandom)});
                3: add_byte(txt, {4'b1110, 4'($urandom)});
                default: add_byte(txt, {5'b11110, 3'($urandom)});
            endcase
            repeat (n - 1)
                if ($urandom_range(0, 1))
                    add_byte(txt, {2'b10, 6'($urandom)});
                else
                    add_byte(txt, 8'($urandom));
        end
        else
            add_byte(txt, 8'($urandom));
    endtask

    task automatic run_random_texts(input int unsigned n_bytes);
        byte_q_t     txt;
        int unsigned len;
        int unsigned stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            txt = {};
            len = $urandom_range(1, 24);
            while (txt.size() < len)
                append_char(txt);
            send_text(txt);
        end
    endtask

    task automatic test_edge_values();
        send_text('{8'h00, 8'hFF, 8'h7F, 8'h80});
    endtask

    task automatic test_multibyte();
        send_text('{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h09});
    endtask

    // scattered continuation bytes, truncated sequences, an invalid lead byte
    task automatic test_fallbacks();
        send_text('{8'hE2, 8'h41, 8'h82, 8'h83, 8'hE2, 8'h82, 8'h41, 8'h41, 8'hF8, 8'hC3});
    endtask

    task automatic test_single_byte_text();
        send_text('{8'h09});
    endtask

    task automatic test_random_back_to_back();
        idle_en = 1'b0;
        run_random_texts(100);
        idle_en = 1'b1;
    endtask

    task automatic test_random_with_idling();
        run_random_texts(230);
    endtask

    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            out_ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 99) < 3)
        begin
            ready_hold = $urandom_range(0, 5);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_out
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected code point %h", code_point));
            else
            begin
                want = pending_chars.pop_front();
                if (code_point !== want.code_point)
                    report_mismatch($sformatf("code_point %h, expected %h",
                                              code_point, want.code_point));
                if (final_char !== want.final_char)
                    report_mismatch($sformatf("final_char %b, expected %b",
                                              final_char, want.final_char));
            end
        end
    end

    initial
    begin
        foreach (win_bytes[i])
            win_bytes[i] = 8'h00;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_edge_values();
        test_multibyte();
        test_fallbacks();
        test_single_byte_text();
        test_random_back_to_back();
        test_random_with_idling();

        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
